// ===== hdl/dktd_pkg.sv =====
// ----------------------------------------------------------------------------
// dktd_pkg
// Shared widths and types for the disk-kernel tile dilation block.
// ----------------------------------------------------------------------------
package dktd_pkg;

   // fixed field widths of the request, response and register words
   localparam int POS_W   = 8;
   localparam int ALPHA_W = 16;
   localparam int CSR_W   = 5;

   // signed working width for coordinates plus or minus a kernel offset
   localparam int COORD_W = 10;

   typedef logic signed [COORD_W-1:0] coord_type;

   // column window and row qualifier handed to the row checker
   typedef struct packed {
      coord_type lo;
      coord_type hi;
      logic      row_ok;
   } window_type;

endpackage

// ===== hdl/dktd_ram.sv =====
// ----------------------------------------------------------------------------
// dktd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dktd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dktd_row_check.sv =====
// ----------------------------------------------------------------------------
// dktd_row_check
// Tests one mask row for an occupied pixel inside a column window.
// ----------------------------------------------------------------------------
module dktd_row_check #(
   parameter int TILE_SIZE = 64
) (
   input  logic [TILE_SIZE-1:0] row_data,
   input  dktd_pkg::window_type win,
   output logic                 hit
);

   logic [TILE_SIZE-1:0] col_hit;

   // per-column window compare, all columns in parallel
   always_comb begin
      for (int c = 0; c < TILE_SIZE; c++) begin
         col_hit[c] = row_data[c]
                      && (dktd_pkg::coord_type'(c) >= win.lo)
                      && (dktd_pkg::coord_type'(c) <= win.hi);
      end
   end

   assign hit = win.row_ok && (|col_hit);

endmodule

// ===== hdl/disk_kernel_tile_dilation.sv =====
// ----------------------------------------------------------------------------
// disk_kernel_tile_dilation
// Binary dilation of a tile occupancy mask with a disk kernel.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per item. req_type 0 loads the mask pixel at
//   (req_pos_x, req_pos_y) as occupied when req_alpha is nonzero; loads outside
//   the tile are dropped. req_type 1 queries the point and returns one rsp_
//   word whose rsp_dilated tells whether an occupied pixel lies in the disk.
//   csr_* writes the radius (reduced modulo MAX_RADIUS+1); write only when idle.
//   One item is worked at a time; req_stall is high until it is done.
// Steps:
//   Load: accept, row read, row write-back.
//   Query: radius 0 goes from accept straight to the answer. Otherwise setup
//   (accept, square), then per kernel row a width check, two mask row reads
//   and a row compare, where the width check steps the shared square/compare
//   unit to narrow the row width; a hit ends the query early.
// Reset: radius clears to 0; the mask is not cleared and must be loaded
//   before it is queried. When rsp_stall holds a pending output word, a finished
//   query waits in its final state and that word stays in the output register.
// ----------------------------------------------------------------------------
module disk_kernel_tile_dilation #(
   parameter int TILE_SIZE  = 64,
   parameter int MAX_RADIUS = 30
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic signed [dktd_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [dktd_pkg::POS_W-1:0] req_pos_y,
   input  logic [dktd_pkg::ALPHA_W-1:0]     req_alpha,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_dilated,
   // radius register write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dktd_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int ADDR_W = $clog2(TILE_SIZE);
   localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
   localparam int SQ_W   = 2 * RAD_W;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_LD_RD = 9'b000000010,
      S_LD_WR = 9'b000000100,
      S_Q_SQ  = 9'b000001000,
      S_Q_FIT = 9'b000010000,
      S_Q_TOP = 9'b000100000,
      S_Q_BOT = 9'b001000000,
      S_Q_CHK = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   // radius reduction as a small constant table
   function automatic logic [RAD_W-1:0] rad_reduce(input logic [dktd_pkg::CSR_W-1:0] v);
      logic [RAD_W-1:0] r;
      r = '0;
      for (int i = 0; i < (1 << dktd_pkg::CSR_W); i++) begin
         if (v == dktd_pkg::CSR_W'(i)) begin
            r = RAD_W'(i % (MAX_RADIUS + 1));
         end
      end
      return r;
   endfunction

   function automatic logic in_tile(input dktd_pkg::coord_type v);
      return (v >= 0) && (v < dktd_pkg::coord_type'(TILE_SIZE));
   endfunction

   state_type           state_ff, state_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   dktd_pkg::coord_type cx_ff, cx_in, cy_ff, cy_in;
   logic                ld_val_ff, ld_val_in;
   logic [RAD_W-1:0]    w_ff, w_in, dy_ff, dy_in;
   logic [SQ_W-1:0]     r2_ff, r2_in, w2_ff, w2_in, dy2_ff, dy2_in;
   logic                top_ok_ff, top_ok_in, bot_ok_ff, bot_ok_in;
   logic                res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_dilated_ff, rsp_dilated_in;

   dktd_pkg::coord_type req_x, req_y, dy_c, row_top, row_bot, rd_row;
   logic [SQ_W-1:0]     rad_sq;
   logic [SQ_W:0]       fit_sum;
   logic                fit_over;
   logic                slot_free;
   logic [RAD_W-1:0]    dy_next;

   logic                ram_wr_en, ram_rd_en;
   logic [TILE_SIZE-1:0] ram_wr_data, ram_rd_data;
   dktd_pkg::window_type win;
   logic                row_hit;

   // request coordinates, sign extended
   assign req_x = dktd_pkg::coord_type'(req_pos_x);
   assign req_y = dktd_pkg::coord_type'(req_pos_y);

   // kernel row offset and the two rows it touches
   assign dy_c    = dktd_pkg::coord_type'({1'b0, dy_ff});
   assign row_top = cy_ff - dy_c;
   assign row_bot = cy_ff + dy_c;
   assign dy_next = dy_ff + RAD_W'(1);

   // shared square/compare unit
   assign rad_sq   = SQ_W'(rad_ff * rad_ff);
   assign fit_sum  = {1'b0, w2_ff} + {1'b0, dy2_ff};
   assign fit_over = fit_sum > {1'b0, r2_ff};

   // column window: cx - (w-1) .. cx + (w-1)
   always_comb begin
      win.lo     = cx_ff - dktd_pkg::coord_type'({1'b0, w_ff}) + dktd_pkg::coord_type'(1);
      win.hi     = cx_ff + dktd_pkg::coord_type'({1'b0, w_ff}) - dktd_pkg::coord_type'(1);
      win.row_ok = (state_ff == S_Q_BOT) ? top_ok_ff : bot_ok_ff;
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // mask row read address
   always_comb begin
      unique case (state_ff)
         S_Q_TOP: rd_row = row_top;
         S_Q_BOT: rd_row = row_bot;
         default: rd_row = cy_ff;
      endcase
   end

   assign ram_rd_en = (state_ff == S_LD_RD) || (state_ff == S_Q_TOP) || (state_ff == S_Q_BOT);
   assign ram_wr_en = (state_ff == S_LD_WR);

   // read-modify-write of one pixel
   always_comb begin
      ram_wr_data = ram_rd_data;
      ram_wr_data[cx_ff[ADDR_W-1:0]] = ld_val_ff;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      ld_val_in = ld_val_ff;
      w_in      = w_ff;
      dy_in     = dy_ff;
      r2_in     = r2_ff;
      w2_in     = w2_ff;
      dy2_in    = dy2_ff;
      top_ok_in = top_ok_ff;
      bot_ok_in = bot_ok_ff;
      res_in    = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cx_in     = req_x;
               cy_in     = req_y;
               ld_val_in = |req_alpha;
               if (!req_type) begin
                  if (in_tile(req_x) && in_tile(req_y)) begin
                     state_in = S_LD_RD;
                  end
               end else if (rad_ff == '0) begin
                  res_in   = 1'b0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_Q_SQ;
               end
            end
         end
         S_LD_RD: state_in = S_LD_WR;
         S_LD_WR: state_in = S_IDLE;
         S_Q_SQ: begin
            r2_in    = rad_sq;
            w2_in    = rad_sq;
            w_in     = rad_ff;
            dy_in    = '0;
            dy2_in   = '0;
            state_in = S_Q_FIT;
         end
         S_Q_FIT: begin
            // shrink w until w*w + dy*dy <= r*r
            if (fit_over) begin
               w_in  = w_ff - RAD_W'(1);
               w2_in = w2_ff - {{(SQ_W-RAD_W-1){1'b0}}, w_ff, 1'b0} + SQ_W'(1);
            end else begin
               state_in = S_Q_TOP;
            end
         end
         S_Q_TOP: begin
            top_ok_in = in_tile(row_top);
            state_in  = S_Q_BOT;
         end
         S_Q_BOT: begin
            bot_ok_in = in_tile(row_bot);
            if (row_hit) begin
               res_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_Q_CHK;
            end
         end
         S_Q_CHK: begin
            if (row_hit) begin
               res_in   = 1'b1;
               state_in = S_DONE;
            end else if (dy_next == rad_ff) begin
               res_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               dy_in    = dy_next;
               dy2_in   = dy2_ff + {{(SQ_W-RAD_W-1){1'b0}}, dy_ff, 1'b1};
               state_in = S_Q_FIT;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_dilated_in = rsp_dilated_ff;
      if ((state_ff == S_DONE) && slot_free) begin
         rsp_valid_in   = 1'b1;
         rsp_dilated_in = res_ff;
      end
   end

   // radius register
   assign rad_in = (csr_valid && csr_ready) ? rad_reduce(csr_wdata) : rad_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rad_ff       <= rad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      ld_val_ff      <= ld_val_in;
      w_ff           <= w_in;
      dy_ff          <= dy_in;
      r2_ff          <= r2_in;
      w2_ff          <= w2_in;
      dy2_ff         <= dy2_in;
      top_ok_ff      <= top_ok_in;
      bot_ok_ff      <= bot_ok_in;
      res_ff         <= res_in;
      rsp_dilated_ff <= rsp_dilated_in;
   end

   // occupancy mask, one tile row per word
   dktd_ram #(
      .WIDTH (TILE_SIZE),
      .DEPTH (TILE_SIZE)
   ) u_mask (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cy_ff[ADDR_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_row[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   dktd_row_check #(
      .TILE_SIZE (TILE_SIZE)
   ) u_row_check (
      .row_data (ram_rd_data),
      .win      (win),
      .hit      (row_hit)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_dilated = rsp_dilated_ff;
   assign csr_ready   = 1'b1;

endmodule

// ===== bench/dktd_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// dktd_tb_pkg
// Request kinds shared by the dilation testbench top and its checker.
// ----------------------------------------------------------------------------
package dktd_tb_pkg;

   // req_type encoding
   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_e;

endpackage

// ===== bench/dilation_monitor.sv =====
// ----------------------------------------------------------------------------
// dilation_monitor
// Watches the request, response and radius write channels of the disk-kernel
// dilation block, keeps its own occupancy mask and radius, predicts the
// dilated bit of every accepted query and compares it with each response word.
// ----------------------------------------------------------------------------
module dilation_monitor
   import dktd_pkg::*;
   import dktd_tb_pkg::*;
#(
   parameter int TILE_SIZE  = 64,
   parameter int MAX_RADIUS = 30
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic                    req_type,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic [ALPHA_W-1:0]      req_alpha,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_dilated,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_W-1:0]        csr_wdata,
   output int                      mismatch_count,
   output int                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic occupancy [TILE_SIZE*TILE_SIZE];
   int   kernel_radius;
   logic expected_dilated_q [$];

   initial begin
      foreach (occupancy[i]) occupancy[i] = 1'b0;
   end

   function automatic logic pixel_occupied(int x, int y);
      if (x < 0 || y < 0 || x >= TILE_SIZE || y >= TILE_SIZE) return 1'b0;
      return occupancy[y*TILE_SIZE + x];
   endfunction

   // disk kernel: row dy spans dx 0..w-1 each side, w = floor(sqrt(r^2-dy^2))
   function automatic logic disk_touches_occupied(int cx, int cy, int r);
      int dy;
      int dx;
      int w;
      for (dy = 0; dy < r; dy++) begin
         w = 0;
         while ((w + 1) * (w + 1) <= r * r - dy * dy) w++;
         for (dx = 0; dx < w; dx++) begin
            if (pixel_occupied(cx + dx, cy - dy) || pixel_occupied(cx + dx, cy + dy) ||
                pixel_occupied(cx - dx, cy - dy) || pixel_occupied(cx - dx, cy + dy))
               return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      int   cx;
      int   cy;
      logic want;
      if (reset) begin
         kernel_radius = 0;
         expected_dilated_q.delete();
      end else begin
         // radius write, reduced modulo MAX_RADIUS+1
         if (csr_valid && csr_ready)
            kernel_radius = int'(csr_wdata) % (MAX_RADIUS + 1);

         // response word against the oldest pending query
         if (rsp_valid && !rsp_stall) begin
            if (expected_dilated_q.size() == 0) begin
               $error("dilated: word with no query pending, actual %0d", rsp_dilated);
               mismatch_count++;
            end else begin
               want = expected_dilated_q.pop_front();
               if (rsp_dilated !== want) begin
                  $error("dilated: expected %0d actual %0d", want, rsp_dilated);
                  mismatch_count++;
               end
            end
         end

         // accepted request word: load updates the mask, query predicts
         if (req_valid && !req_stall) begin
            cx = int'(req_pos_x);
            cy = int'(req_pos_y);
            if (req_type == REQ_LOAD) begin
               if (cx >= 0 && cy >= 0 && cx < TILE_SIZE && cy < TILE_SIZE)
                  occupancy[cy*TILE_SIZE + cx] = (req_alpha != '0);
            end else begin
               expected_dilated_q.push_back(kernel_radius != 0 &&
                                            disk_touches_occupied(cx, cy, kernel_radius));
            end
         end
      end
      pending_count = expected_dilated_q.size();
   end

endmodule

// ===== bench/tb_disk_kernel_tile_dilation.sv =====
// ----------------------------------------------------------------------------
// tb_disk_kernel_tile_dilation
// Loads the top band of the tile mask, runs directed loads and queries at the
// coordinate and radius extremes, then random phases at several radii with
// random idling on both channels. Checking is done by dilation_monitor.
// ----------------------------------------------------------------------------
module tb_disk_kernel_tile_dilation;
   import dktd_pkg::*;
   import dktd_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TILE_SIZE     = 64;
   localparam int MAX_RADIUS    = 30;
   localparam int ROWS_LOADED   = 16;
   localparam int SETTLE_CYCLES = 8;
   localparam int WORDS_PER_RUN = 90;
   localparam int CYCLE_LIMIT   = 3_000_000;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   logic                    req_type    = REQ_LOAD;
   logic signed [POS_W-1:0] req_pos_x   = '0;
   logic signed [POS_W-1:0] req_pos_y   = '0;
   logic [ALPHA_W-1:0]      req_alpha   = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   logic                    rsp_dilated;
   logic                    csr_valid   = 1'b0;
   logic                    csr_ready;
   logic [CSR_W-1:0]        csr_wdata   = '0;

   int   mismatch_count;
   int   pending_count;
   int   cycle_count  = 0;
   bit   idling_on    = 1'b1;
   int   stall_left   = 0;
   int   query_radius = 0;
   logic seed_map [ROWS_LOADED][TILE_SIZE];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   disk_kernel_tile_dilation DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_alpha   (req_alpha),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_dilated (rsp_dilated),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   dilation_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_alpha      (req_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_dilated    (rsp_dilated),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_disk_kernel_tile_dilation: FAIL");
         $finish;
      end
   end

   // response back-pressure in random bursts
   always @(negedge clock) begin
      if (!idling_on || reset) begin
         rsp_stall  = 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall  = 1'b1;
         stall_left = $urandom_range(0, 15);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // one request word; called and returns at a falling edge
   task automatic send_word(req_kind_e kind, int x, int y, int a);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_type  = kind;
      req_pos_x = x[POS_W-1:0];
      req_pos_y = y[POS_W-1:0];
      req_alpha = a[ALPHA_W-1:0];
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // hold the sender until every query has answered and the block is quiet
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_radius(int value);
      wait_drained();
      csr_valid = 1'b1;
      csr_wdata = value[CSR_W-1:0];
      query_radius = int'(value[CSR_W-1:0]) % (MAX_RADIUS + 1);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // query point: mostly the window -30..93, sometimes any byte
   function automatic int query_coord();
      if ($urandom_range(0, 19) < 3) return int'($urandom_range(0, 255)) - 128;
      return int'($urandom_range(0, 123)) - 30;
   endfunction

   // query row whose kernel rows stay in the loaded band or off the tile
   function automatic int query_row();
      int top_max;
      int bot_min;
      int lo;
      int hi;
      bit wide;
      if (query_radius == 0) return query_coord();
      top_max = ROWS_LOADED - query_radius;
      bot_min = TILE_SIZE - 1 + query_radius;
      wide    = ($urandom_range(0, 19) < 3);
      lo      = wide ? -128 : -30;
      hi      = wide ? 127 : 93;
      if ($urandom_range(0, 3) != 0) return lo + int'($urandom_range(0, top_max - lo));
      return bot_min + int'($urandom_range(0, hi - bot_min));
   endfunction

   function automatic int load_coord();
      if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 255)) - 128;
      return int'($urandom_range(0, TILE_SIZE - 1));
   endfunction

   initial begin
      int run_radius [10] = '{1, 0, 2, 31, 30, 3, -1, -1, 2, -1};
      int x;
      int y;
      int run;
      int n;
      int a;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sparse seed pixels: the four band corners plus a few random ones
      foreach (seed_map[i, j]) seed_map[i][j] = 1'b0;
      seed_map[0][0] = 1'b1;
      seed_map[0][TILE_SIZE-1] = 1'b1;
      seed_map[ROWS_LOADED-1][0] = 1'b1;
      seed_map[ROWS_LOADED-1][TILE_SIZE-1] = 1'b1;
      repeat (8) seed_map[$urandom_range(0, ROWS_LOADED-1)][$urandom_range(0, TILE_SIZE-1)] = 1'b1;

      // load the top band; query kernels stay inside it or off the tile
      for (y = 0; y < ROWS_LOADED; y++) begin
         for (x = 0; x < TILE_SIZE; x++) begin
            a = seed_map[y][x] ? int'($urandom_range(1, 65535)) : 0;
            send_word(REQ_LOAD, x, y, a);
         end
      end

      // directed: zero radius after reset answers 0 even on an occupied pixel
      send_word(REQ_QUERY, 0, 0, 0);

      // radius 1 kernel is the point itself
      set_radius(1);
      send_word(REQ_QUERY, 0, 0, 0);
      send_word(REQ_QUERY, -1, -1, 0);
      send_word(REQ_LOAD, 32, 32, 16'h8000);
      send_word(REQ_QUERY, 32, 32, 0);
      send_word(REQ_LOAD, 32, 32, 0);
      send_word(REQ_QUERY, 32, 32, 16'hffff);
      send_word(REQ_LOAD, 32, 32, 16'h0001);
      send_word(REQ_QUERY, 32, 32, 0);

      // loads outside the tile are dropped
      send_word(REQ_LOAD, 64, 10, 16'hffff);
      send_word(REQ_LOAD, 10, -1, 16'hffff);
      send_word(REQ_LOAD, -128, 127, 16'hffff);
      send_word(REQ_LOAD, 127, -128, 16'hffff);
      send_word(REQ_QUERY, 64, 10, 0);

      // largest radius at the far corners of the query window and beyond
      set_radius(30);
      send_word(REQ_QUERY, -30, -30, 0);
      send_word(REQ_QUERY, 93, 93, 0);
      send_word(REQ_QUERY, -128, -128, 0);
      send_word(REQ_QUERY, 127, 127, 0);
      send_word(REQ_QUERY, 31, -14, 0);
      send_word(REQ_QUERY, -30, 93, 0);

      // 31 wraps to radius 0
      set_radius(31);
      send_word(REQ_QUERY, 0, 0, 0);
      set_radius(2);
      send_word(REQ_QUERY, 1, 1, 0);

      // random runs, one radius each; the last one without idling
      for (run = 0; run < 10; run++) begin
         set_radius(run_radius[run] < 0 ? int'($urandom_range(1, 7)) : run_radius[run]);
         idling_on = (run != 9) && ($urandom_range(0, 3) != 0);
         for (n = 0; n < WORDS_PER_RUN; n++) begin
            if ($urandom_range(0, 9) < 4) begin
               a = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 65535)) : 0;
               send_word(REQ_LOAD, load_coord(), load_coord(), a);
            end else begin
               send_word(REQ_QUERY, query_coord(), query_row(),
                         int'($urandom_range(0, 65535)));
            end
         end
      end

      idling_on = 1'b0;
      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("tb_disk_kernel_tile_dilation: PASS");
      else
         $display("tb_disk_kernel_tile_dilation: FAIL");
      $finish;
   end

endmodule
